@@ rtl/core/olmid_pkg.sv @@
// Shared types and constants for the ordered list with middle insert and delete.
`timescale 1ns / 1ps
package olmid_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int LEN_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OP_W        = 3;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_INS_MID    = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REM_MID    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_SHORT = 2'd2,
        STS_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  removed_value;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic in_stall;
        logic out_valid;
        logic load;
    } t_ctl;

endpackage

@@ rtl/core/ordered_list_mid_insert_delete.sv @@
// Top level of the ordered list with push, pop and middle insert/remove.
//
// Input channel: i_in_valid / o_in_stall carry one operation word
// (operation, entry_value). Output channel: o_out_valid / i_out_stall
// carry one result word (status, removed_value, entry_count) per operation.
// An operation is executed in the cycle it is accepted; its result is
// registered and shows in the next cycle.
// When not stalled, throughput is one operation per cycle: every entry
// register loads from its own value, a neighbor or the input through a
// small mux, and the result register refills in the cycle its word is taken.
// While a result waits under i_out_stall, o_in_stall is high and the
// result word holds; with no result waiting the input is never stalled.
// Reset empties the list and clears the result slot. Entry contents are
// not cleared; positions past the current length may be shifted but are never read out.
`timescale 1ns / 1ps
module ordered_list_mid_insert_delete (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  olmid_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output olmid_pkg::t_out_item o_out_data
);
    import olmid_pkg::*;

    t_ctl ctl;

    olmid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl)
    );

    olmid_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ctl.load),
        .i_item   (i_in_data),
        .o_result (o_out_data)
    );

    assign o_in_stall  = ctl.in_stall;
    assign o_out_valid = ctl.out_valid;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STS_FULL)
        |-> o_out_data.entry_count == COUNT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STS_EMPTY)
        |-> (o_out_data.entry_count == '0 && o_out_data.removed_value == '0))
        else $error("empty status with entries or removed word");

    a_drop_only_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("result dropped while stalled");

endmodule

@@ rtl/core/olmid_ctrl.sv @@
// Handshake controller: owns the result slot and issues the load command.
`timescale 1ns / 1ps
module olmid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    output olmid_pkg::t_ctl  o_ctl
);
    import olmid_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && !((r_state == ST_HOLD) && i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                // refill the slot in the same cycle the old word leaves
                if (!accept && !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.in_stall  = 1'b0;
        o_ctl.out_valid = 1'b0;
        o_ctl.load      = accept;
        case (r_state)
            ST_IDLE: begin
                o_ctl.in_stall  = 1'b0;
                o_ctl.out_valid = 1'b0;
            end
            ST_HOLD: begin
                o_ctl.in_stall  = i_out_stall;
                o_ctl.out_valid = 1'b1;
            end
            default: begin
                o_ctl.in_stall  = 1'b1;
                o_ctl.out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/olmid_dp.sv @@
// Datapath: entry registers with neighbor shift muxes, length and result register.
`timescale 1ns / 1ps
module olmid_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  olmid_pkg::t_in_item  i_item,
    output olmid_pkg::t_out_item o_result
);
    import olmid_pkg::*;

    logic [VALUE_WIDTH-1:0] r_entry [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_entry [CAPACITY];
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    t_out_item              r_result;
    t_out_item              n_result;

    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] removed;
    logic [LEN_W-1:0]       pos;
    logic                   do_ins;
    logic                   do_rem;
    t_status                status;

    // decode the operation against the current length
    always_comb begin
        value  = VALUE_WIDTH'(i_item.entry_value);
        do_ins = 1'b0;
        do_rem = 1'b0;
        pos    = '0;
        status = STS_DONE;
        case (i_item.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (r_len >= LEN_W'(CAPACITY)) begin
                    status = STS_FULL;
                end else begin
                    do_ins = 1'b1;
                    pos    = (i_item.operation == OP_PUSH_BACK) ? r_len : '0;
                end
            end
            OP_INS_MID: begin
                if (r_len == '0) begin
                    status = STS_EMPTY;
                end else if (r_len < LEN_W'(2)) begin
                    status = STS_SHORT;
                end else if (r_len >= LEN_W'(CAPACITY)) begin
                    status = STS_FULL;
                end else begin
                    do_ins = 1'b1;
                    pos    = (r_len + LEN_W'(1)) >> 1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (r_len == '0) begin
                    status = STS_EMPTY;
                end else begin
                    do_rem = 1'b1;
                    pos    = (i_item.operation == OP_POP_FRONT) ? '0 : r_len - LEN_W'(1);
                end
            end
            OP_REM_MID: begin
                if (r_len == '0) begin
                    status = STS_EMPTY;
                end else if (r_len < LEN_W'(2)) begin
                    status = STS_SHORT;
                end else begin
                    do_rem = 1'b1;
                    pos    = r_len >> 1;
                end
            end
            default: status = STS_DONE;
        endcase
    end

    assign removed = do_rem ? r_entry[pos[IDX_W-1:0]] : '0;

    // each entry takes its own value, the new word, or a neighbor
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[IDX_W'(i)] = r_entry[IDX_W'(i)];
            if (do_ins) begin
                if (LEN_W'(i) == pos) begin
                    n_entry[IDX_W'(i)] = value;
                end else if (LEN_W'(i) > pos) begin
                    n_entry[IDX_W'(i)] = r_entry[IDX_W'((i == 0) ? 0 : i - 1)];
                end
            end else if (do_rem) begin
                if (LEN_W'(i) >= pos) begin
                    n_entry[IDX_W'(i)] = r_entry[IDX_W'((i == CAPACITY - 1) ? i : i + 1)];
                end
            end
        end
    end

    always_comb begin
        if (do_ins) begin
            n_len = r_len + LEN_W'(1);
        end else if (do_rem) begin
            n_len = r_len - LEN_W'(1);
        end else begin
            n_len = r_len;
        end
        n_result.status        = status;
        n_result.removed_value = WORD_W'(removed);
        n_result.entry_count   = COUNT_W'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry  <= n_entry;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_load) begin
            r_len <= n_len;
        end
    end

    assign o_result = r_result;

endmodule
